// ----- sv/ryptf_pkg.sv -----
// ============================================================================
// ryptf_pkg
// Shared types, register indexes, states and constant tables of the lidar
// point time and blind-range filter.
// ============================================================================
package ryptf_pkg;

    // One lidar point as it enters the block
    typedef struct packed {
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic signed [19:0] pos_z;
        logic        [15:0] echo_strength;
        logic        [62:0] raw_time;
        logic        [6:0]  ring;
        logic               times_given;
        logic               frame_start;
    } point_t;

    // One kept point as it leaves the block
    typedef struct packed {
        logic signed [19:0] out_x;
        logic signed [19:0] out_y;
        logic signed [19:0] out_z;
        logic        [15:0] out_strength;
        logic        [31:0] offset_time_ns;
    } result_t;

    // Classified point, front to back
    typedef struct packed {
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic signed [19:0] pos_z;
        logic        [15:0] strength;
        logic        [62:0] raw_time;
        logic        [6:0]  ring;
        logic               given;   // frame carries per-point times
        logic               first;   // first point of its ring this frame
        logic               keep;    // index is a multiple of decimation
    } cmd_t;

    // Configuration register indexes
    localparam logic [2:0] REG_SCAN_RATE  = 3'd0;
    localparam logic [2:0] REG_BLIND      = 3'd1;
    localparam logic [2:0] REG_DECIMATION = 3'd2;
    localparam logic [2:0] REG_TIME_UNIT  = 3'd3;

    // Back end sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RUN,
        ST_TMUL1,
        ST_TMUL2,
        ST_TSUM,
        ST_DMUL,
        ST_DIV,
        ST_FIX,
        ST_OUT
    } back_state_t;

    localparam logic [23:0] HALF_TURN = 24'h800000;
    localparam logic [31:0] NS_MAX    = 32'hFFFF_FFFF;
    // 360e9 / 361 ns per turn at 1 Hz, numerator part
    localparam logic [39:0] TURN_NUM  = 40'd360000000000;

    // Arctangent of 2^-i as a 24-bit fraction of a turn
    function automatic logic [23:0] atan_turn(input logic [4:0] idx);
        logic [23:0] v;
        case (idx)
            5'd0:    v = 24'd2097152;
            5'd1:    v = 24'd1238021;
            5'd2:    v = 24'd654136;
            5'd3:    v = 24'd332050;
            5'd4:    v = 24'd166669;
            5'd5:    v = 24'd83416;
            5'd6:    v = 24'd41718;
            5'd7:    v = 24'd20860;
            5'd8:    v = 24'd10430;
            5'd9:    v = 24'd5215;
            5'd10:   v = 24'd2608;
            5'd11:   v = 24'd1304;
            5'd12:   v = 24'd652;
            5'd13:   v = 24'd326;
            5'd14:   v = 24'd163;
            5'd15:   v = 24'd81;
            5'd16:   v = 24'd41;
            5'd17:   v = 24'd20;
            5'd18:   v = 24'd10;
            5'd19:   v = 24'd5;
            5'd20:   v = 24'd3;
            5'd21:   v = 24'd1;
            5'd22:   v = 24'd1;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

    // Nanoseconds per raw time unit
    function automatic logic [29:0] time_factor(input logic [1:0] unit_sel);
        logic [29:0] f;
        case (unit_sel)
            2'd0:    f = 30'd1000000000;
            2'd1:    f = 30'd1000000;
            2'd2:    f = 30'd1000;
            default: f = 30'd1;
        endcase
        return f;
    endfunction

    // Two restoring division steps: {remainder, two quotient bits}
    function automatic logic [17:0] div2_step(input logic [15:0] rem,
                                              input logic [1:0]  bits,
                                              input logic [15:0] d);
        logic [16:0] r1;
        logic [16:0] r2;
        logic        q1;
        logic        q0;
        r1 = {rem, bits[1]};
        q1 = (r1 >= {1'b0, d});
        if (q1)
            r1 = r1 - {1'b0, d};
        r2 = {r1[15:0], bits[0]};
        q0 = (r2 >= {1'b0, d});
        if (q0)
            r2 = r2 - {1'b0, d};
        return {r2[15:0], q1, q0};
    endfunction

endpackage

// ----- sv/ryptf_front.sv -----
// ============================================================================
// ryptf_front
// Accepts points, keeps the frame index and ring marks, and passes the
// points that need work on to the back end.
// ============================================================================
module ryptf_front #(
    parameter int RINGS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  ryptf_pkg::point_t point,
    input  logic [7:0]        decimation,
    output logic              cmd_push,
    output ryptf_pkg::cmd_t   cmd,
    input  logic              cmd_full
);
    import ryptf_pkg::*;

    localparam int RING_W = (RINGS > 1) ? $clog2(RINGS) : 1;

    logic [7:0]       idx_reg, idx_next;
    logic [RINGS-1:0] seen_reg, seen_next;
    logic [RINGS-1:0] seen_base;
    logic [7:0]       idx_cur;
    logic [7:0]       dec;
    logic [8:0]       idx_inc;
    logic [RING_W-1:0] ring_idx;
    logic             ring_ok;
    logic             first;
    logic             drop;
    logic             accept;

    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    // Classification of the incoming point
    always_comb
    begin
        seen_base = point.frame_start ? '0 : seen_reg;
        idx_cur   = point.frame_start ? 8'd0 : idx_reg;
        dec       = (decimation == 8'd0) ? 8'd1 : decimation;
        idx_inc   = {1'b0, idx_cur} + 9'd1;
        ring_ok   = ({1'b0, point.ring} < 8'(RINGS));
        ring_idx  = point.ring[RING_W-1:0];
        first     = ring_ok ? !seen_base[ring_idx] : 1'b0;
        drop      = point.times_given ? (idx_cur != 8'd0) : !ring_ok;

        idx_next  = idx_reg;
        seen_next = seen_reg;
        if (accept)
        begin
            idx_next  = (idx_inc >= {1'b0, dec}) ? 8'd0 : idx_inc[7:0];
            seen_next = seen_base;
            if (!point.times_given && ring_ok)
                seen_next[ring_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            seen_reg <= '0;
        end
        else
        begin
            idx_reg  <= idx_next;
            seen_reg <= seen_next;
        end
    end

    // Command toward the back end
    assign cmd_push     = accept && !drop;
    assign cmd.pos_x    = point.pos_x;
    assign cmd.pos_y    = point.pos_y;
    assign cmd.pos_z    = point.pos_z;
    assign cmd.strength = point.echo_strength;
    assign cmd.raw_time = point.raw_time;
    assign cmd.ring     = point.ring;
    assign cmd.given    = point.times_given;
    assign cmd.first    = first;
    assign cmd.keep     = (idx_cur == 8'd0);

endmodule

// ----- sv/ryptf_cmd_fifo.sv -----
// ============================================================================
// ryptf_cmd_fifo
// Two-entry queue of classified points between front and back end.
// ============================================================================
module ryptf_cmd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  ryptf_pkg::cmd_t wr_data,
    output logic            full,
    output logic            avail,
    input  logic            rd_en,
    output ryptf_pkg::cmd_t rd_data
);
    import ryptf_pkg::*;

    cmd_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign avail   = (count_reg != 2'd0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

// ----- sv/ryptf_back.sv -----
// ============================================================================
// ryptf_back
// Works out yaw (iterative CORDIC), range, and offset time of one point at a
// time, keeps the per-ring yaw and time memories, and holds the result.
// ============================================================================
module ryptf_back #(
    parameter int RINGS        = 32,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_avail,
    input  ryptf_pkg::cmd_t    cmd,
    output logic               cmd_pop,
    input  logic [6:0]         scan_rate_hz,
    input  logic [15:0]        blind_mm,
    input  logic [1:0]         time_scale,
    output ryptf_pkg::result_t result,
    output logic               empty,
    input  logic               pop
);
    import ryptf_pkg::*;

    localparam int RING_W   = (RINGS > 1) ? $clog2(RINGS) : 1;
    // last CORDIC update lands at cnt = CORDIC_STEPS-1, yaw is final in the cycle after
    localparam int RUN_LAST = (CORDIC_STEPS > 4) ? CORDIC_STEPS : 4;
    localparam int DIV_LAST = 19;
    localparam int CW       = 34;

    back_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg;

    cmd_t                 cmd_reg;
    logic [4:0]           cnt_reg;
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic [23:0]          cz_reg;
    logic                 zero_reg;
    logic [41:0]          acc_reg;
    logic [31:0]          blind2_reg;
    logic [61:0]          p1_reg;
    logic [53:0]          p2_reg;
    logic                 sat_reg;
    logic [39:0]          nq_reg, tr_reg;
    logic [15:0]          rq_reg, rt_reg;
    logic [15:0]          d_reg;
    logic [31:0]          t_reg;

    logic [23:0] yaw_mem  [RINGS];
    logic [31:0] last_mem [RINGS];
    logic [23:0] yaw_rd_reg;
    logic [31:0] last_rd_reg;

    logic                 yaw_we, last_we, load_out;
    logic [31:0]          last_wdata;
    logic [23:0]          yaw;
    logic                 keep_ok;
    logic [31:0]          t_fix, t_given;
    logic [40:0]          fix_sum;
    logic [62:0]          given_sum;
    logic [RING_W-1:0]    wr_addr, rd_addr;
    logic signed [19:0]   sq_a;
    logic signed [39:0]   sq_prod;
    logic signed [CW-1:0] xe, ye, dx, dy;
    logic [23:0]          delta;
    logic [63:0]          dprod;
    logic [15:0]          rate16;
    logic [17:0]          dstep_t, dstep_r;

    assign rd_addr = cmd.ring[RING_W-1:0];
    assign wr_addr = cmd_reg.ring[RING_W-1:0];
    assign yaw     = zero_reg ? 24'd0 : cz_reg;
    assign keep_ok = cmd_reg.keep && (acc_reg > {10'd0, blind2_reg});
    assign result  = out_reg;
    assign empty   = !out_valid_reg;

    // Datapath helpers
    always_comb
    begin
        xe = CW'(cmd.pos_x);
        ye = CW'(cmd.pos_y);
        if (cmd.pos_x < 0)
        begin
            xe = -xe;
            ye = -ye;
        end
        dx = cy_reg >>> cnt_reg;
        dy = cx_reg >>> cnt_reg;

        case (cnt_reg)
            5'd0:    sq_a = cmd_reg.pos_x;
            5'd1:    sq_a = cmd_reg.pos_y;
            5'd2:    sq_a = cmd_reg.pos_z;
            default: sq_a = {4'd0, blind_mm};
        endcase
        sq_prod = sq_a * sq_a;

        delta  = yaw_rd_reg - yaw;
        dprod  = 64'(delta) * 64'(TURN_NUM);
        rate16 = (scan_rate_hz == 7'd0) ? 16'd1 : {9'd0, scan_rate_hz};

        dstep_t = div2_step(rq_reg, nq_reg[39:38], d_reg);
        dstep_r = div2_step(rt_reg, tr_reg[39:38], d_reg);

        // yaw time: add one turn when time went backward
        if (nq_reg < {8'd0, last_rd_reg})
            fix_sum = {1'b0, nq_reg} + {1'b0, tr_reg};
        else
            fix_sum = {1'b0, nq_reg};
        t_fix = (fix_sum > {9'd0, NS_MAX}) ? NS_MAX : fix_sum[31:0];

        // given time: whole part plus fraction part
        given_sum = {1'b0, p1_reg} + 63'(p2_reg[53:24]);
        t_given   = (sat_reg || given_sum > {31'd0, NS_MAX}) ? NS_MAX : given_sum[31:0];
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        yaw_we     = 1'b0;
        last_we    = 1'b0;
        last_wdata = t_fix;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_avail)
                begin
                    cmd_pop    = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cnt_reg == 5'(RUN_LAST))
                begin
                    if (cmd_reg.given)
                        state_next = ST_TMUL1;
                    else if (cmd_reg.first)
                    begin
                        yaw_we     = 1'b1;
                        last_we    = 1'b1;
                        last_wdata = '0;
                        state_next = ST_IDLE;
                    end
                    else
                        state_next = ST_DMUL;
                end
            end
            ST_TMUL1: state_next = ST_TMUL2;
            ST_TMUL2: state_next = ST_TSUM;
            ST_TSUM:  state_next = keep_ok ? ST_OUT : ST_IDLE;
            ST_DMUL:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == 5'(DIV_LAST))
                    state_next = ST_FIX;
            end
            ST_FIX:
            begin
                last_we    = 1'b1;
                state_next = keep_ok ? ST_OUT : ST_IDLE;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || pop)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        out_valid_next = (out_valid_reg && !pop) || load_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_avail)
                begin
                    cmd_reg  <= cmd;
                    cnt_reg  <= 5'd0;
                    acc_reg  <= '0;
                    cx_reg   <= xe <<< 8;
                    cy_reg   <= ye <<< 8;
                    cz_reg   <= (cmd.pos_x < 0) ? HALF_TURN : 24'd0;
                    zero_reg <= (cmd.pos_x == 20'sd0) && (cmd.pos_y == 20'sd0);
                end
            end
            ST_RUN:
            begin
                if (cnt_reg < 5'(CORDIC_STEPS))
                begin
                    if (cy_reg >= 0)
                    begin
                        cx_reg <= cx_reg + dx;
                        cy_reg <= cy_reg - dy;
                        cz_reg <= cz_reg + atan_turn(cnt_reg);
                    end
                    else
                    begin
                        cx_reg <= cx_reg - dx;
                        cy_reg <= cy_reg + dy;
                        cz_reg <= cz_reg - atan_turn(cnt_reg);
                    end
                end
                if (cnt_reg < 5'd3)
                    acc_reg <= acc_reg + 42'($unsigned(sq_prod));
                if (cnt_reg == 5'd3)
                    blind2_reg <= sq_prod[31:0];
                cnt_reg <= cnt_reg + 5'd1;
            end
            ST_TMUL1:
            begin
                sat_reg <= |cmd_reg.raw_time[62:56];
                p1_reg  <= 62'(cmd_reg.raw_time[55:24]) * 62'(time_factor(time_scale));
            end
            ST_TMUL2:
            begin
                p2_reg <= 54'(cmd_reg.raw_time[23:0]) * 54'(time_factor(time_scale));
            end
            ST_TSUM:
            begin
                t_reg <= t_given;
            end
            ST_DMUL:
            begin
                nq_reg  <= dprod[63:24];
                tr_reg  <= TURN_NUM;
                rq_reg  <= '0;
                rt_reg  <= '0;
                d_reg   <= 16'(rate16 * 16'd361);
                cnt_reg <= 5'd0;
            end
            ST_DIV:
            begin
                nq_reg  <= {nq_reg[37:0], dstep_t[1:0]};
                rq_reg  <= dstep_t[17:2];
                tr_reg  <= {tr_reg[37:0], dstep_r[1:0]};
                rt_reg  <= dstep_r[17:2];
                cnt_reg <= cnt_reg + 5'd1;
            end
            ST_FIX:
            begin
                t_reg <= t_fix;
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    out_reg.out_x          <= cmd_reg.pos_x;
                    out_reg.out_y          <= cmd_reg.pos_y;
                    out_reg.out_z          <= cmd_reg.pos_z;
                    out_reg.out_strength   <= cmd_reg.strength;
                    out_reg.offset_time_ns <= t_reg;
                end
            end
            default: ;
        endcase
    end

    // Per-ring yaw and time memories
    always_ff @(posedge clk)
    begin
        if (yaw_we)
            yaw_mem[wr_addr] <= yaw;
        if (last_we)
            last_mem[wr_addr] <= last_wdata;
        if (cmd_pop)
        begin
            yaw_rd_reg  <= yaw_mem[rd_addr];
            last_rd_reg <= last_mem[rd_addr];
        end
    end

    // Checks
    a_idle_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !cmd_avail) |=> state_reg == ST_IDLE)
        else $error("back end left idle without a command");

    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIX) |-> (nq_reg[39:30] == 10'd0))
        else $error("yaw time quotient out of range");

    a_out_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && !out_valid_reg) |=> out_valid_reg)
        else $error("free result slot not filled");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == ST_IDLE && cmd_avail))
        else $error("command taken while busy");

endmodule

// ----- sv/ring_yaw_point_time_filter_unit.sv -----
// ============================================================================
// ring_yaw_point_time_filter_unit
// Lidar point time and blind-range filter: decimates points, drops points
// inside the blind range, and tags kept points with a time offset in ns.
// ============================================================================
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------
//  point    | push / full        | point_t  (one lidar point)
//  result   | pop / empty        | result_t (one kept point)
//  config   | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A point in yaw mode is taken, runs the 16 CORDIC iterations and range
// sums, one multiply, a two-bit-per-cycle divider and one fix-up, and
// loads the result once the result slot is free. With given times, two
// multiplies and a sum replace the multiply, divider and fix-up; the
// first point of a ring stops after the CORDIC. Points dropped at the
// front take no back-end time. The command queue holds two points, so
// input is taken while the back end works or a result waits. Reset clears
// state; the ring memories need no clearing pass.
// ============================================================================
module ring_yaw_point_time_filter_unit #(
    parameter int RINGS        = 32,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  ryptf_pkg::point_t  point,
    output logic               empty,
    input  logic               pop,
    output ryptf_pkg::result_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import ryptf_pkg::*;

    logic [6:0]  scan_rate_reg;
    logic [15:0] blind_reg;
    logic [7:0]  decim_reg;
    logic [1:0]  unit_reg;

    logic cmd_push, cmd_full, cmd_avail, cmd_pop;
    cmd_t cmd_in, cmd_out;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_rate_reg <= 7'd10;
            blind_reg     <= 16'd0;
            decim_reg     <= 8'd1;
            unit_reg      <= 2'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SCAN_RATE:  scan_rate_reg <= cfg_data[6:0];
                REG_BLIND:      blind_reg     <= cfg_data;
                REG_DECIMATION: decim_reg     <= cfg_data[7:0];
                REG_TIME_UNIT:  unit_reg      <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    ryptf_front #(
        .RINGS (RINGS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .point      (point),
        .decimation (decim_reg),
        .cmd_push   (cmd_push),
        .cmd        (cmd_in),
        .cmd_full   (cmd_full)
    );

    ryptf_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .avail   (cmd_avail),
        .rd_en   (cmd_pop),
        .rd_data (cmd_out)
    );

    ryptf_back #(
        .RINGS        (RINGS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_avail    (cmd_avail),
        .cmd          (cmd_out),
        .cmd_pop      (cmd_pop),
        .scan_rate_hz (scan_rate_reg),
        .blind_mm     (blind_reg),
        .time_scale   (unit_reg),
        .result       (result),
        .empty        (empty),
        .pop          (pop)
    );

endmodule

// ----- bench/ring_yaw_point_time_filter_unit_tb.sv -----
// ============================================================================
// ring_yaw_point_time_filter_unit_tb
// Drives lidar points through the filter under several register settings,
// predicts every kept point and its time offset, and checks each result
// transfer against the oldest prediction. Both sides idle at random.
// ============================================================================
module ring_yaw_point_time_filter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ryptf_pkg::*;

    localparam int NRINGS = 32;
    localparam int STEPS  = 16;
    localparam int ITEMS_PER_PHASE = 70;

    // Arctangent of 2^-i in 24-bit turn fractions
    localparam bit [23:0] ATAN_TURN [STEPS] = '{
        24'd2097152, 24'd1238021, 24'd654136, 24'd332050, 24'd166669, 24'd83416,
        24'd41718, 24'd20860, 24'd10430, 24'd5215, 24'd2608, 24'd1304, 24'd652,
        24'd326, 24'd163, 24'd81};

    // Predicts kept points and holds them until the block delivers them
    class point_time_scoreboard;
        int unsigned rate_hz, blind, decim, unit_sel, index_mod;
        bit          seen [NRINGS];
        bit [23:0]   first_yaw [NRINGS];
        bit [31:0]   last_ns [NRINGS];
        result_t     kept_q [$];
        int          errors;

        function new();
            rate_hz = 10; blind = 0; decim = 1; unit_sel = 2; index_mod = 0;
            errors = 0;
            foreach (seen[r])
            begin
                seen[r] = 0; first_yaw[r] = 0; last_ns[r] = 0;
            end
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                REG_SCAN_RATE:  rate_hz  = data[6:0];
                REG_BLIND:      blind    = data;
                REG_DECIMATION: decim    = data[7:0];
                REG_TIME_UNIT:  unit_sel = data[1:0];
                default: ;
            endcase
        endfunction

        function bit [23:0] yaw_of(longint x, longint y);
            bit [23:0] z;
            longint dx, dy;
            z = 0;
            if (x == 0 && y == 0)
                return 0;
            if (x < 0)
            begin
                x = -x; y = -y; z = 24'h800000;
            end
            x = x * 256; y = y * 256;
            for (int i = 0; i < STEPS; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0)
                begin
                    x += dx; y -= dy; z += ATAN_TURN[i];
                end
                else
                begin
                    x -= dx; y += dy; z -= ATAN_TURN[i];
                end
            end
            return z;
        endfunction

        function bit [63:0] scaled_ns(bit [62:0] raw);
            bit [63:0] f, whole, frac, t;
            case (unit_sel)
                0: f = 64'd1000000000;
                1: f = 64'd1000000;
                2: f = 64'd1000;
                default: f = 64'd1;
            endcase
            whole = raw >> 24;
            frac  = raw[23:0];
            if (whole > 64'hFFFF_FFFF)
                return 64'hFFFF_FFFF;
            t = whole * f + ((frac * f) >> 24);
            return (t > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : t;
        endfunction

        // Accepted point: update state and queue the kept point, if any
        function void note_point(point_t p);
            longint    x, y, z;
            bit [63:0] t, rate, turn, range2;
            bit [23:0] yaw, delta;
            int unsigned dec_eff, cur;
            result_t   r;
            x = $signed(p.pos_x); y = $signed(p.pos_y); z = $signed(p.pos_z);
            dec_eff = (decim == 0) ? 1 : decim;
            if (p.frame_start)
            begin
                foreach (seen[i])
                    seen[i] = 0;
                index_mod = 0;
            end
            cur = index_mod;
            index_mod = (cur + 1 >= dec_eff) ? 0 : ((cur + 1) & 8'hFF);
            if (p.times_given)
                t = scaled_ns(p.raw_time);
            else
            begin
                if (p.ring >= NRINGS)
                    return;
                yaw = yaw_of(x, y);
                if (!seen[p.ring])
                begin
                    seen[p.ring] = 1;
                    first_yaw[p.ring] = yaw;
                    last_ns[p.ring] = 0;
                    return;
                end
                rate  = (rate_hz == 0) ? 1 : rate_hz;
                delta = first_yaw[p.ring] - yaw;
                t     = (64'(delta) * 64'd360000000000) / ((64'd361 * rate) << 24);
                turn  = 64'd360000000000 / (64'd361 * rate);
                if (t < last_ns[p.ring])
                begin
                    t += turn;
                    if (t > 64'hFFFF_FFFF)
                        t = 64'hFFFF_FFFF;
                end
                last_ns[p.ring] = t[31:0];
            end
            if (cur != 0)
                return;
            range2 = x * x + y * y + z * z;
            if (range2 <= 64'(blind) * 64'(blind))
                return;
            r.out_x = p.pos_x; r.out_y = p.pos_y; r.out_z = p.pos_z;
            r.out_strength = p.echo_strength;
            r.offset_time_ns = t[31:0];
            kept_q.insert(kept_q.size(), r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (kept_q.size() == 0)
            begin
                $display("%0t: unexpected result, actual %p", $realtime, got);
                errors++;
                return;
            end
            want = kept_q.pop_front();
            if (got.out_x != want.out_x || got.out_y != want.out_y ||
                got.out_z != want.out_z || got.out_strength != want.out_strength ||
                got.offset_time_ns != want.offset_time_ns)
            begin
                $display("%0t: result mismatch, expected %p, actual %p",
                         $realtime, want, got);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    point_t      point;
    logic        empty;
    logic        pop;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    point_time_scoreboard sb = new();

    ring_yaw_point_time_filter_unit uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .point(point),
        .empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Result side: random pop pattern, check on every result transfer
    initial
    begin
        pop = 0;
        @(posedge rst_n);
        forever
        begin
            pop <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            if ($urandom_range(0, 2) == 0)
            begin
                pop <= 1'b0;
                repeat (idle_len() + 1) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
        if (rst_n && pop && !empty)
            sb.check_result(result);

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    // Push one point; push stays high when the next point follows at once
    task automatic send_point(point_t p, bit hold);
        int gap;
        push  <= 1'b1;
        point <= p;
        do @(posedge clk); while (full);
        sb.note_point(p);
        if (!hold)
        begin
            gap = idle_len();
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_random(point_t p);
        send_point(p, ($urandom_range(0, 3) == 0));
    endtask

    // Block idle: nothing expected, and time for points that yield nothing
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (sb.kept_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic point_t mk(int x, int y, int z, bit [6:0] ring,
                                  bit given, bit fs, bit [62:0] raw = 0);
        point_t p;
        p.pos_x = 20'(x); p.pos_y = 20'(y); p.pos_z = 20'(z);
        p.echo_strength = 16'($urandom);
        p.raw_time = raw;
        p.ring = ring;
        p.times_given = given;
        p.frame_start = fs;
        return p;
    endfunction

    function automatic int rand_coord();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return ($urandom_range(0, 1)) ? 524287 : -524288;
        if (r < 5)
            return $signed($urandom_range(0, 800)) - 400;
        return $signed(20'($urandom));
    endfunction

    function automatic bit [62:0] rand_raw();
        bit [62:0] v;
        v = 63'({$urandom, $urandom});
        if ($urandom_range(0, 2) != 0)
            v = v >> $urandom_range(8, 40);
        return v;
    endfunction

    // One frame of random points; yaw frames reuse a few rings
    task automatic send_frame(int n, bit given, bit fs);
        point_t   p;
        bit [6:0] ring;
        int       rings;
        rings = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                ring = 7'($urandom_range(NRINGS, 127));
            else if ($urandom_range(0, 9) == 0)
                ring = 7'($urandom_range(0, NRINGS - 1));
            else
                ring = 7'($urandom_range(0, rings - 1));
            p = mk(rand_coord(), rand_coord(), rand_coord(), ring,
                   given, (i == 0) && fs, rand_raw());
            // a little noise: a stray time flag inside a frame
            if ($urandom_range(0, 39) == 0)
                p.times_given = ~given;
            send_random(p);
        end
    endtask

    initial
    begin
        bit [15:0] phase_cfg [6][4];
        int        sent;
        int        n;
        phase_cfg = '{'{10, 0, 1, 2}, '{1, 0, 1, 0}, '{100, 65535, 255, 3},
                      '{0, 300, 0, 1}, '{37, 1000, 3, 2}, '{127, 20000, 2, 0}};
        rst_n = 0; push = 0; point = '0;
        cfg_valid = 0; cfg_index = '0; cfg_data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: yaw quadrants, origin, extremes, unknown rings, wraps, times
        write_reg(REG_SCAN_RATE, 10);
        write_reg(REG_BLIND, 0);
        write_reg(REG_DECIMATION, 1);
        write_reg(REG_TIME_UNIT, 2);
        send_point(mk(1000, 0, 0, 0, 0, 1), 0);
        send_point(mk(0, 1000, 5, 0, 0, 0), 1);
        send_point(mk(-1000, 0, -5, 0, 0, 0), 0);
        send_point(mk(0, -1000, 0, 0, 0, 0), 0);
        send_point(mk(999, 10, 0, 0, 0, 0), 0);
        send_point(mk(0, 0, 0, 1, 0, 0), 0);
        send_point(mk(0, 0, 7, 1, 0, 0), 0);
        send_point(mk(524287, -524288, 524287, 31, 0, 0), 0);
        send_point(mk(-524288, 524287, -524288, 31, 0, 0), 0);
        send_point(mk(5, 5, 5, NRINGS, 0, 0), 0);
        send_point(mk(5, 5, 5, 127, 0, 0), 0);
        send_point(mk(-524288, -524288, -524288, 0, 1, 1, 0), 0);
        send_point(mk(524287, 524287, 524287, 127, 1, 0, '1), 1);
        send_point(mk(1, 0, 0, 3, 1, 0, 63'h1234_5678_9ABC), 0);
        send_point(mk(0, 0, 1, 3, 1, 0, 63'hFF_FFFF), 0);
        send_point(mk(0, 0, 0, 3, 1, 0, 63'h10_0000_0000), 0);
        drain();

        // Random phases, one register setting each
        sent = 0;
        for (int ph = 0; ph < 6; ph++)
        begin
            for (int k = 0; k < 4; k++)
                write_reg(k[2:0], phase_cfg[ph][k]);
            n = 0;
            while (n < ITEMS_PER_PHASE)
            begin
                int len;
                bit given;
                len   = $urandom_range(8, 40);
                given = ($urandom_range(0, 3) == 0);
                // a frame may continue the previous one across a setting change
                send_frame(len, given, !(n == 0 && $urandom_range(0, 1)));
                n += len;
            end
            sent += n;
            drain();
        end

        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end
endmodule
